// ===== hdl/frame_bitmap_allocator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator assertion macros
// Shared macros for the concurrent checks of the allocator.
// ----------------------------------------------------------------------------
`ifndef FRAME_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FRAME_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is applied.
`define FBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// Next-cycle implication, disabled while reset is applied.
`define FBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`else

`define FBA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FBA_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/fba_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator package
// Sizes, request and status codes, state type and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package fba_pkg;

    // Store geometry: one used bit per frame, 64 frames to a word.
    localparam int MAX_FRAMES_N = 65536;
    localparam int WORD_BITS    = 64;
    localparam int WORDS        = MAX_FRAMES_N / WORD_BITS;
    localparam int WORD_AW      = $clog2(WORDS);
    localparam int SCAN_W       = WORD_AW + 1;
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int FRAME_W      = 16;
    localparam int CNT_W        = 17;
    localparam int GROUP_BITS   = 8;
    localparam int GROUPS       = WORD_BITS / GROUP_BITS;
    localparam int GROUP_IW     = $clog2(GROUPS);
    localparam int GBIT_W       = $clog2(GROUP_BITS);

    localparam logic [CNT_W-1:0] MAX_FRAMES = CNT_W'(MAX_FRAMES_N);

    typedef enum logic [1:0] {
        REQ_TEST  = 2'd0,
        REQ_MARK  = 2'd1,
        REQ_REL   = 2'd2,
        REQ_ALLOC = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_FREE = 2'd1,
        STAT_RANGE   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_FIND,
        S_RESP
    } t_state;

    // Result of the lowest-free-bit finder.
    typedef struct packed {
        logic             done;
        logic [BIT_W-1:0] idx;
    } t_find_res;

    // Index of the lowest set bit in a group; zero when none is set.
    function automatic logic [GBIT_W-1:0] f_lowest_group(input logic [GROUP_BITS-1:0] v);
        logic [GBIT_W-1:0] idx;
        idx = '0;
        for (int i = GROUP_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = GBIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/fba_req_if.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator request channel
// Valid/ready channel that carries one allocator request.
// ----------------------------------------------------------------------------
`default_nettype none

interface fba_req_if;

    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] frame_number;

    modport source (
        output valid,
        output req_type,
        output frame_number,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  frame_number,
        output ready
    );

endinterface

`default_nettype wire

// ===== hdl/fba_res_if.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator result channel
// Valid/ready channel that carries one allocator result.
// ----------------------------------------------------------------------------
`default_nettype none

interface fba_res_if;

    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        frame_was_used;
    logic [15:0] alloc_frame;
    logic [16:0] used_total;
    logic [16:0] free_total;

    modport source (
        output valid,
        output status,
        output frame_was_used,
        output alloc_frame,
        output used_total,
        output free_total,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  frame_was_used,
        input  alloc_frame,
        input  used_total,
        input  free_total,
        output ready
    );

endinterface

`default_nettype wire

// ===== hdl/frame_bitmap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator
// Page-frame allocator with one used bit per frame in a 1024 x 64 bit RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bitmap RAM to zero, one word a cycle, and
// accepts no request meanwhile; the frame count register can be written at
// any time. It works on one request at a time. For a test, mark or release
// the word is read in the transfer cycle, then read-modify-written unless the
// frame is out of range, and then the result register is loaded. An allocate
// scans the bitmap one word per cycle through the single RAM read port,
// starting at the lowest word that may still hold a free frame; a hit is then
// resolved to a bit by the finder, first its byte and then the bit in it.
// The result register lets a new request be taken while the previous result
// still waits for its transfer; a second finished request then waits until
// that register is free.
`default_nettype none
`include "frame_bitmap_allocator_unit_defines.svh"

module frame_bitmap_allocator_unit
    import fba_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [CNT_W-1:0] i_cfg_wr_data,
    fba_req_if.sink               i_req,
    fba_res_if.source             o_res
);

    // Control registers.
    t_state              r_state, n_state;
    logic [WORD_AW-1:0]  r_clr_addr, n_clr_addr;
    logic [CNT_W-1:0]    r_frame_count, n_frame_count;
    logic [CNT_W-1:0]    r_used_cnt, n_used_cnt;
    logic [SCAN_W-1:0]   r_hint, n_hint;
    logic [SCAN_W-1:0]   r_word, n_word;
    logic                r_pend, n_pend;
    logic                r_out_valid, n_out_valid;

    // Payload registers.
    logic [SCAN_W-1:0]   r_pend_word, n_pend_word;
    logic [1:0]          r_req_type, n_req_type;
    logic [FRAME_W-1:0]  r_frame, n_frame;
    logic [WORD_BITS-1:0] r_data, n_data;
    logic [WORD_AW-1:0]  r_hit_word, n_hit_word;
    t_status             r_res_status, n_res_status;
    logic                r_res_was, n_res_was;
    logic [FRAME_W-1:0]  r_res_grant, n_res_grant;
    t_status             r_out_status, n_out_status;
    logic                r_out_was, n_out_was;
    logic [FRAME_W-1:0]  r_out_grant, n_out_grant;
    logic [CNT_W-1:0]    r_out_used, n_out_used;
    logic [CNT_W-1:0]    r_out_free, n_out_free;

    // RAM and finder connections.
    logic                 ram_we;
    logic [WORD_AW-1:0]   ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_AW-1:0]   ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic                 find_start;
    t_find_res            find_res;

    // Shared scan and update terms.
    logic [CNT_W-1:0]     lim;
    logic [CNT_W-1:0]     pend_rem;
    logic [WORD_BITS-1:0] lim_mask;
    logic [WORD_BITS-1:0] avail;
    logic [WORD_BITS-1:0] bit_sel;
    logic                 old_bit;
    logic                 in_xfer;

    // Terms used by the checks at the end.
    logic                 grant_now;
    logic [CNT_W-1:0]     grant_frame;
    logic [CNT_W-1:0]     used_inc;

    // Frame count saturated to the store size.
    assign lim = (r_frame_count > MAX_FRAMES) ? MAX_FRAMES : r_frame_count;

    // Free bits of the pending scan word that lie below the frame count.
    assign pend_rem = lim - {r_pend_word, {BIT_W{1'b0}}};
    assign lim_mask = (pend_rem >= CNT_W'(WORD_BITS)) ? {WORD_BITS{1'b1}}
                    : ~({WORD_BITS{1'b1}} << pend_rem[BIT_W-1:0]);
    assign avail    = ~ram_rdata & lim_mask;

    // Bit of the addressed frame within its word.
    assign bit_sel = WORD_BITS'(1) << r_frame[BIT_W-1:0];
    assign old_bit = |(ram_rdata & bit_sel);

    assign i_req.ready = (r_state == S_IDLE);
    assign in_xfer     = i_req.valid && i_req.ready;

    // Sequencer: next state, RAM access and result values.
    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_frame_count = i_cfg_wr_en ? i_cfg_wr_data : r_frame_count;
        n_used_cnt    = r_used_cnt;
        n_hint        = r_hint;
        n_word        = r_word;
        n_pend        = r_pend;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_pend_word   = r_pend_word;
        n_req_type    = r_req_type;
        n_frame       = r_frame;
        n_data        = r_data;
        n_hit_word    = r_hit_word;
        n_res_status  = r_res_status;
        n_res_was     = r_res_was;
        n_res_grant   = r_res_grant;
        n_out_status  = r_out_status;
        n_out_was     = r_out_was;
        n_out_grant   = r_out_grant;
        n_out_used    = r_out_used;
        n_out_free    = r_out_free;
        ram_we        = 1'b0;
        ram_waddr     = r_frame[FRAME_W-1:BIT_W];
        ram_wdata     = ram_rdata;
        ram_raddr     = r_word[WORD_AW-1:0];
        find_start    = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + WORD_AW'(1);
                if (r_clr_addr == WORD_AW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (in_xfer) begin
                    n_req_type  = i_req.req_type;
                    n_frame     = i_req.frame_number;
                    n_res_was   = 1'b0;
                    n_res_grant = '0;
                    if (i_req.req_type == REQ_ALLOC) begin
                        // Start the scan at the hint word.
                        ram_raddr   = r_hint[WORD_AW-1:0];
                        n_pend      = ({r_hint, {BIT_W{1'b0}}} < lim);
                        n_pend_word = r_hint;
                        n_word      = r_hint + SCAN_W'(1);
                        n_state     = S_SCAN;
                    end else begin
                        ram_raddr = i_req.frame_number[FRAME_W-1:BIT_W];
                        if ({1'b0, i_req.frame_number} >= lim) begin
                            n_res_status = STAT_RANGE;
                            n_state      = S_RESP;
                        end else begin
                            n_state = S_MOD;
                        end
                    end
                end
            end

            S_MOD: begin
                // Read-modify-write of the addressed word.
                n_res_status = STAT_OK;
                n_res_was    = old_bit;
                ram_waddr    = r_frame[FRAME_W-1:BIT_W];
                if (r_req_type == REQ_MARK && !old_bit) begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata | bit_sel;
                    n_used_cnt = r_used_cnt + CNT_W'(1);
                end else if (r_req_type == REQ_REL && old_bit) begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata & ~bit_sel;
                    n_used_cnt = r_used_cnt - CNT_W'(1);
                    if ({1'b0, r_frame[FRAME_W-1:BIT_W]} < r_hint) begin
                        n_hint = {1'b0, r_frame[FRAME_W-1:BIT_W]};
                    end
                end
                n_state = S_RESP;
            end

            S_SCAN: begin
                // Check the word read last cycle and fetch the next one.
                if (!r_pend) begin
                    n_res_status = STAT_NO_FREE;
                    n_state      = S_RESP;
                end else if (|avail) begin
                    find_start = 1'b1;
                    n_data     = ram_rdata;
                    n_hit_word = r_pend_word[WORD_AW-1:0];
                    n_state    = S_FIND;
                end else begin
                    n_pend      = ({r_word, {BIT_W{1'b0}}} < lim);
                    n_pend_word = r_word;
                    n_word      = r_word + SCAN_W'(1);
                end
            end

            S_FIND: begin
                // Grant the lowest free bit of the hit word.
                if (find_res.done) begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_hit_word;
                    ram_wdata    = r_data | (WORD_BITS'(1) << find_res.idx);
                    n_used_cnt   = r_used_cnt + CNT_W'(1);
                    n_hint       = {1'b0, r_hit_word};
                    n_res_status = STAT_OK;
                    n_res_grant  = {r_hit_word, find_res.idx};
                    n_state      = S_RESP;
                end
            end

            S_RESP: begin
                // Load the result register once it is free.
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_was    = r_res_was;
                    n_out_grant  = r_res_grant;
                    n_out_used   = r_used_cnt;
                    n_out_free   = (lim > r_used_cnt) ? (lim - r_used_cnt) : '0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_frame_count <= MAX_FRAMES;
            r_used_cnt    <= '0;
            r_hint        <= '0;
            r_word        <= '0;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr_addr    <= n_clr_addr;
            r_frame_count <= n_frame_count;
            r_used_cnt    <= n_used_cnt;
            r_hint        <= n_hint;
            r_word        <= n_word;
            r_pend        <= n_pend;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload state.
    always_ff @(posedge i_clk) begin
        r_pend_word  <= n_pend_word;
        r_req_type   <= n_req_type;
        r_frame      <= n_frame;
        r_data       <= n_data;
        r_hit_word   <= n_hit_word;
        r_res_status <= n_res_status;
        r_res_was    <= n_res_was;
        r_res_grant  <= n_res_grant;
        r_out_status <= n_out_status;
        r_out_was    <= n_out_was;
        r_out_grant  <= n_out_grant;
        r_out_used   <= n_out_used;
        r_out_free   <= n_out_free;
    end

    // Bitmap store.
    fba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Lowest free bit finder.
    fba_find u_find (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (find_start),
        .i_vec   (avail),
        .o_res   (find_res)
    );

    // Result channel.
    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_out_status;
    assign o_res.frame_was_used = r_out_was;
    assign o_res.alloc_frame    = r_out_grant;
    assign o_res.used_total     = r_out_used;
    assign o_res.free_total     = r_out_free;

    // A grant is written in the cycle the finder reports its result.
    assign grant_now   = (r_state == S_FIND) && find_res.done;
    assign grant_frame = {1'b0, r_hit_word, find_res.idx};
    assign used_inc    = r_used_cnt + CNT_W'(1);

    // Checks on the sequencer and the counters.
    `FBA_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_state != S_IDLE, !i_req.ready)
    `FBA_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_used_cnt <= MAX_FRAMES)
    `FBA_ASSERT_IMP(a_grant_in_range, i_clk, i_rst_n, grant_now, grant_frame < lim)
    `FBA_ASSERT_NXT(a_grant_counts, i_clk, i_rst_n, grant_now, r_used_cnt == $past(used_inc))

endmodule

`default_nettype wire

// ===== hdl/fba_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/fba_find.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator lowest-bit finder
// Two-step search for the lowest set bit of a word: first the lowest
// non-empty byte, then the lowest bit inside it.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_find
    import fba_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [WORD_BITS-1:0] i_vec,
    output t_find_res                 o_res
);

    logic [GROUPS-1:0]     grp_nz;
    logic [GROUP_IW-1:0]   grp_sel;
    logic                  r_busy;
    logic                  r_done;
    logic [GROUP_IW-1:0]   r_grp;
    logic [GROUP_BITS-1:0] r_bits;
    logic [BIT_W-1:0]      r_idx;

    // Mark every byte that holds a set bit and pick the lowest one.
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            grp_nz[g] = |i_vec[g*GROUP_BITS +: GROUP_BITS];
        end
        grp_sel = f_lowest_group(grp_nz);
    end

    // Control: the first step runs on start, the second in the cycle after.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    // Data path of both steps.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_grp  <= grp_sel;
            r_bits <= i_vec[{grp_sel, {GBIT_W{1'b0}}} +: GROUP_BITS];
        end
        if (r_busy) begin
            r_idx <= {r_grp, f_lowest_group(r_bits)};
        end
    end

    assign o_res.done = r_done;
    assign o_res.idx  = r_idx;

endmodule

`default_nettype wire

// ===== sim/frame_bitmap_allocator_unit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator result checker
// Watches the configuration port and both channels of the allocator. It keeps
// its own copy of the used-frame bitmap, the used counter and the frame count.
// From these it works out the result of every request transfer. Each result
// transfer is then compared, field by field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_unit_checker
    import fba_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [CNT_W-1:0] i_cfg_wr_data,
    fba_req_if                    i_req,
    fba_res_if                    i_res,
    output int                    o_pending,
    output int                    o_errors
);

    typedef struct packed {
        t_status            status;
        logic               was_used;
        logic [FRAME_W-1:0] grant;
        logic [CNT_W-1:0]   used;
        logic [CNT_W-1:0]   free;
    } t_alloc_reply;

    logic [WORD_BITS-1:0] frame_map [WORDS];
    int unsigned          used_frames;
    logic [CNT_W-1:0]     frame_count_reg;
    t_alloc_reply         replies_due [$];
    int                   outstanding = 0;
    int                   mismatches  = 0;

    assign o_pending = outstanding;
    assign o_errors  = mismatches;

    task automatic report_mismatch(input string msg);
        $display("%0t: allocator mismatch, %s", $time, msg);
        mismatches++;
    endtask

    // Frames at or above MAX_FRAMES do not exist, so the count saturates.
    function automatic int unsigned managed_frames();
        return (frame_count_reg > MAX_FRAMES) ? MAX_FRAMES_N : int'(frame_count_reg);
    endfunction

    // Lowest clear bit below the frame count, or -1 when every frame is taken.
    function automatic int lowest_free_frame(input int unsigned lim);
        int unsigned base;
        int unsigned span;
        for (int w = 0; w < WORDS; w++) begin
            base = w * WORD_BITS;
            if (base >= lim) begin
                return -1;
            end
            if (frame_map[w] != '1) begin
                span = (lim - base > WORD_BITS) ? WORD_BITS : lim - base;
                for (int b = 0; b < span; b++) begin
                    if (!frame_map[w][b]) begin
                        return base + b;
                    end
                end
            end
        end
        return -1;
    endfunction

    // Applies one request to the bitmap copy and queues the reply it earns.
    task automatic predict_frame_request(input t_req_type rt, input logic [FRAME_W-1:0] fn);
        int unsigned  lim;
        int           hit;
        logic         old;
        t_alloc_reply r;
        lim = managed_frames();
        r   = '0;
        if (rt == REQ_ALLOC) begin
            hit = lowest_free_frame(lim);
            if (hit < 0) begin
                r.status = STAT_NO_FREE;
            end else begin
                frame_map[hit / WORD_BITS][hit % WORD_BITS] = 1'b1;
                used_frames++;
                r.grant = FRAME_W'(hit);
            end
        end else if (fn >= lim) begin
            r.status = STAT_RANGE;
        end else begin
            old        = frame_map[fn / WORD_BITS][fn % WORD_BITS];
            r.was_used = old;
            if (rt == REQ_MARK && !old) begin
                frame_map[fn / WORD_BITS][fn % WORD_BITS] = 1'b1;
                used_frames++;
            end else if (rt == REQ_REL && old) begin
                frame_map[fn / WORD_BITS][fn % WORD_BITS] = 1'b0;
                used_frames--;
            end
        end
        // Frames left set above a lowered count still count as used.
        r.used = CNT_W'(used_frames);
        r.free = (lim > used_frames) ? CNT_W'(lim - used_frames) : '0;
        replies_due.push_back(r);
    endtask

    task automatic check_reply();
        t_alloc_reply exp;
        if (replies_due.size() == 0) begin
            report_mismatch("result transfer with no request outstanding");
        end else begin
            exp = replies_due.pop_front();
            if (i_res.status !== exp.status) begin
                report_mismatch($sformatf("status got %0d, expected %0d",
                                          i_res.status, exp.status));
            end
            if (i_res.frame_was_used !== exp.was_used) begin
                report_mismatch($sformatf("frame_was_used got %0d, expected %0d",
                                          i_res.frame_was_used, exp.was_used));
            end
            if (i_res.alloc_frame !== exp.grant) begin
                report_mismatch($sformatf("alloc_frame got %0d, expected %0d",
                                          i_res.alloc_frame, exp.grant));
            end
            if (i_res.used_total !== exp.used) begin
                report_mismatch($sformatf("used_total got %0d, expected %0d",
                                          i_res.used_total, exp.used));
            end
            if (i_res.free_total !== exp.free) begin
                report_mismatch($sformatf("free_total got %0d, expected %0d",
                                          i_res.free_total, exp.free));
            end
        end
    endtask

    // The result is checked before the request of the same edge is applied,
    // as it always belongs to an earlier request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < WORDS; w++) begin
                frame_map[w] = '0;
            end
            used_frames     = 0;
            frame_count_reg = MAX_FRAMES;
            replies_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                frame_count_reg = i_cfg_wr_data;
            end
            if (i_res.valid && i_res.ready) begin
                check_reply();
            end
            if (i_req.valid && i_req.ready) begin
                predict_frame_request(t_req_type'(i_req.req_type), i_req.frame_number);
            end
        end
        outstanding = replies_due.size();
    end

endmodule

// ===== sim/frame_bitmap_allocator_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator testbench
// Drives directed and random request streams into the allocator. The frame
// count changes between phases, and both channels idle at random. The result
// checker beside the block does the comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_unit_tb;
    import fba_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;
    int               send_gap_pct;
    int               take_gap_pct;
    bit               hold_results;
    int               pending;
    int               errors;

    fba_req_if req_ch ();
    fba_res_if res_ch ();

    frame_bitmap_allocator_unit DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_ch),
        .o_res         (res_ch)
    );

    frame_bitmap_allocator_unit_checker frame_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_ch),
        .i_res         (res_ch),
        .o_pending     (pending),
        .o_errors      (errors)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        res_ch.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (hold_results) begin
                hold_results = 1'b0;
                stall_left   = 299;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= take_gap_pct);
            end
        end
    end

    // Valid stays high between back-to-back transfers; it drops only for a gap or while the bench waits for results.
    task automatic send_request(input t_req_type rt, input logic [FRAME_W-1:0] fn);
        @(negedge clk);
        if ($urandom_range(99) < send_gap_pct) begin
            req_ch.valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < send_gap_pct);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= rt;
        req_ch.frame_number <= fn;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // The frame count is only changed once the block has nothing in flight.
    task automatic set_frame_count(input logic [CNT_W-1:0] value);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic t_req_type pick_request();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35) begin
            return REQ_ALLOC;
        end else if (r < 55) begin
            return REQ_MARK;
        end else if (r < 85) begin
            return REQ_REL;
        end
        return REQ_TEST;
    endfunction

    // Mostly frames in the low region where allocations land, some around the
    // frame count boundary and some anywhere.
    function automatic logic [FRAME_W-1:0] pick_frame(input int unsigned eff);
        int unsigned r;
        int unsigned hot;
        int unsigned hi;
        r   = $urandom_range(99);
        hot = (eff < 300) ? eff + eff / 8 + 2 : 300;
        hi  = (eff + 3 > 65535) ? 65535 : eff + 3;
        if (r < 15) begin
            return FRAME_W'($urandom);
        end else if (r < 30 && eff >= 4) begin
            return FRAME_W'($urandom_range(hi, eff - 4));
        end
        return FRAME_W'($urandom_range(hot));
    endfunction

    initial begin
        logic [CNT_W-1:0] stage_limit;
        int unsigned      eff;
        int               stage_items;
        int               item_no;
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_TEST;
        req_ch.frame_number = '0;
        send_gap_pct        = 38;
        take_gap_pct        = 65;
        hold_results        = 1'b0;
        item_no             = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: edges of the frame range, repeated marks and releases,
        // allocation from an empty pool and from one with no frames, and a lowered count.
        set_frame_count(MAX_FRAMES);
        send_request(REQ_TEST, 16'd0);
        send_request(REQ_TEST, 16'hFFFF);
        send_request(REQ_MARK, 16'hFFFF);
        send_request(REQ_MARK, 16'hFFFF);
        send_request(REQ_TEST, 16'hFFFF);
        send_request(REQ_REL, 16'hFFFF);
        send_request(REQ_REL, 16'hFFFF);
        send_request(REQ_ALLOC, 16'h5A5A);
        send_request(REQ_ALLOC, 16'd0);
        send_request(REQ_MARK, 16'd0);
        send_request(REQ_REL, 16'd0);
        send_request(REQ_ALLOC, 16'hFFFF);
        set_frame_count(17'd0);
        send_request(REQ_TEST, 16'd0);
        send_request(REQ_ALLOC, 16'd0);
        send_request(REQ_REL, 16'd1);
        set_frame_count(17'd1);
        send_request(REQ_ALLOC, 16'd0);
        send_request(REQ_TEST, 16'd0);
        set_frame_count(17'd3);
        send_request(REQ_ALLOC, 16'd0);
        send_request(REQ_ALLOC, 16'd0);
        send_request(REQ_MARK, 16'd3);
        // A count beyond the store saturates at its size.
        set_frame_count(17'h1FFFF);
        send_request(REQ_TEST, 16'hFFFF);
        send_request(REQ_ALLOC, 16'd0);
        send_request(REQ_MARK, 16'hFFFF);

        // Random phases, each under its own frame count.
        for (int stage = 0; stage < 10; stage++) begin
            case (stage)
                0: begin stage_limit = MAX_FRAMES;              stage_items = 120; end
                1: begin stage_limit = 17'd100;                 stage_items = 100; end
                2: begin stage_limit = 17'd64;                  stage_items = 80;  end
                3: begin stage_limit = 17'd1;                   stage_items = 40;  end
                4: begin stage_limit = 17'd0;                   stage_items = 30;  end
                5: begin stage_limit = CNT_W'($urandom_range(400, 2));  stage_items = 100; end
                6: begin stage_limit = 17'd130;                 stage_items = 100; end
                7: begin stage_limit = 17'h1FFFF;               stage_items = 80;  end
                8: begin stage_limit = 17'd65535;               stage_items = 60;  end
                default: begin
                    stage_limit = CNT_W'($urandom_range(1000, 1));
                    stage_items = 60;
                end
            endcase
            eff = (stage_limit > MAX_FRAMES) ? MAX_FRAMES_N : int'(stage_limit);
            set_frame_count(stage_limit);
            for (int k = 0; k < stage_items; k++) begin
                if (item_no < 250) begin
                    send_gap_pct = 38;
                    take_gap_pct = 65;
                end else if (item_no < 500) begin
                    send_gap_pct = 65;
                    take_gap_pct = 38;
                end else begin
                    send_gap_pct = 0;
                    take_gap_pct = 0;
                end
                if (item_no == 100 || item_no == 600) begin
                    hold_results = 1'b1;
                end
                send_request(pick_request(), pick_frame(eff));
                item_no++;
            end
        end

        wait_for_results();
        repeat (20) @(posedge clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(50_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/fba_pkg.sv
hdl/fba_req_if.sv
hdl/fba_res_if.sv
hdl/fba_ram.sv
hdl/fba_find.sv
hdl/frame_bitmap_allocator_unit.sv
sim/frame_bitmap_allocator_unit_checker.sv
sim/frame_bitmap_allocator_unit_tb.sv
